/* sv/clock_buffer_pool_manager_top_defines.svh */
// Assertion macros shared by the buffer pool manager files.
`ifndef CLOCK_BUFFER_POOL_MANAGER_TOP_DEFINES_SVH
`define CLOCK_BUFFER_POOL_MANAGER_TOP_DEFINES_SVH

// Implication checked at every rising clock edge outside reset.
`define CBPM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define CBPM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/cbpm_pkg.sv */
package cbpm_pkg;

   localparam int DefNumFrames = 16;
   localparam int FrameIdxW    = 4;
   localparam int FileW        = 8;
   localparam int PageW        = 20;
   localparam int PinW         = 8;
   localparam int KindW        = 3;
   localparam int StatusW      = 3;
   localparam logic [PinW-1:0] PinMax = '1;

   localparam logic [KindW-1:0] KIND_READ     = 3'd0;
   localparam logic [KindW-1:0] KIND_UNPIN    = 3'd1;
   localparam logic [KindW-1:0] KIND_ALLOC    = 3'd2;
   localparam logic [KindW-1:0] KIND_DISPOSE  = 3'd3;
   localparam logic [KindW-1:0] KIND_FLUSH    = 3'd4;

   localparam logic [StatusW-1:0] ST_OK         = 3'd0;
   localparam logic [StatusW-1:0] ST_ALL_PINNED = 3'd1;
   localparam logic [StatusW-1:0] ST_NOT_FOUND  = 3'd2;
   localparam logic [StatusW-1:0] ST_NOT_PINNED = 3'd3;
   localparam logic [StatusW-1:0] ST_PAGE_PINNED = 3'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch_req;   // capture request fields
      logic scan_clr;    // reset the scan index and the sweep count
      logic scan_step;   // move the scan index on
      logic hit_upd;     // update the matched frame on a read hit
      logic unpin_upd;   // drop one pin on the matched frame
      logic clear_match; // dispose the matched frame
      logic hand_step;   // advance the hand and visit its frame
      logic place;       // load the request into the victim frame
      logic flush_clear; // clear the frame under the scan index
      logic rsp_load;    // load the result register
      logic [StatusW-1:0] rsp_status;
      logic rsp_frame;   // result carries a frame index
      logic rsp_hit;
      logic rsp_load_needed;
      logic rsp_wb;      // result carries write-back tags
      logic rsp_wb_scan; // write-back tags come from the scan frame
      logic rsp_last;
   } cbpm_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [KindW-1:0] kind;
      logic scan_match;  // scan frame valid and both tags equal
      logic file_match;  // scan frame valid and file tag equal
      logic scan_pinned;
      logic scan_dirty;
      logic scan_pin_zero;
      logic scan_last;   // scan index at the final frame
      logic hand_take;   // frame after the hand is a victim
      logic sweep_done;  // two passes used up
   } cbpm_stat_type;

endpackage

/* sv/clock_buffer_pool_manager_top.sv */
// Channel  Handshake              Payload
// req      req_valid/req_ready    req_kind, req_file_id, req_page_no, req_dirty_flag
// rsp      rsp_valid/rsp_ready    rsp_status ... rsp_last (one or more items per request)
//
// One request at a time. Unpin and dispose scan the frames for a match; a
// read miss then sweeps the clock hand, one frame visited per cycle, for up
// to two passes and places the request in the victim frame, and an
// allocate skips the lookup and goes straight to the sweep.
// Flush visits one frame per cycle, stops to report a dirty frame, ends on a pinned one; results wait for rsp_ready.
// Synchronous active-high reset clears every frame's valid, dirty, ref and
// pin state and sets the hand to the last frame; no clearing pass is needed.
module clock_buffer_pool_manager_top
   import cbpm_pkg::*;
#(
   parameter int NUM_FRAMES = DefNumFrames
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [KindW-1:0]     req_kind,
   input  logic [FileW-1:0]     req_file_id,
   input  logic [PageW-1:0]     req_page_no,
   input  logic                 req_dirty_flag,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [StatusW-1:0]   rsp_status,
   output logic [FrameIdxW-1:0] rsp_frame_index,
   output logic                 rsp_hit,
   output logic                 rsp_load_needed,
   output logic                 rsp_writeback_valid,
   output logic [FileW-1:0]     rsp_writeback_file,
   output logic [PageW-1:0]     rsp_writeback_page,
   output logic                 rsp_last
);

   cbpm_cmd_type  cmd;
   cbpm_stat_type stat;

   cbpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cbpm_datapath #(.NUM_FRAMES(NUM_FRAMES)) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_kind            (req_kind),
      .req_file_id         (req_file_id),
      .req_page_no         (req_page_no),
      .req_dirty_flag      (req_dirty_flag),
      .rsp_status          (rsp_status),
      .rsp_frame_index     (rsp_frame_index),
      .rsp_hit             (rsp_hit),
      .rsp_load_needed     (rsp_load_needed),
      .rsp_writeback_valid (rsp_writeback_valid),
      .rsp_writeback_file  (rsp_writeback_file),
      .rsp_writeback_page  (rsp_writeback_page),
      .rsp_last            (rsp_last)
   );

endmodule

/* sv/cbpm_datapath.sv */
`include "clock_buffer_pool_manager_top_defines.svh"

module cbpm_datapath
   import cbpm_pkg::*;
#(
   parameter int NUM_FRAMES = DefNumFrames
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cbpm_cmd_type         cmd,
   output cbpm_stat_type        stat,
   input  logic [KindW-1:0]     req_kind,
   input  logic [FileW-1:0]     req_file_id,
   input  logic [PageW-1:0]     req_page_no,
   input  logic                 req_dirty_flag,
   output logic [StatusW-1:0]   rsp_status,
   output logic [FrameIdxW-1:0] rsp_frame_index,
   output logic                 rsp_hit,
   output logic                 rsp_load_needed,
   output logic                 rsp_writeback_valid,
   output logic [FileW-1:0]     rsp_writeback_file,
   output logic [PageW-1:0]     rsp_writeback_page,
   output logic                 rsp_last
);

   localparam int IdxW = $clog2(NUM_FRAMES);
   localparam int CntW = $clog2(2 * NUM_FRAMES + 1);
   localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_FRAMES - 1);
   localparam logic [CntW-1:0] SweepMax = CntW'(2 * NUM_FRAMES);

   logic [NUM_FRAMES-1:0] valid_ff, dirty_ff, ref_ff;
   logic [PinW-1:0]       pins_ff [NUM_FRAMES];
   logic [FileW-1:0]      file_ff [NUM_FRAMES];
   logic [PageW-1:0]      page_ff [NUM_FRAMES];
   logic [IdxW-1:0]       hand_ff, hand_in, scan_ff, victim_ff;
   logic [CntW-1:0]       sweep_cnt_ff;
   logic [KindW-1:0]      kind_ff;
   logic [FileW-1:0]      file_id_ff;
   logic [PageW-1:0]      page_no_ff;
   logic                  dflag_ff;

   logic [StatusW-1:0]    st_ff;
   logic [FrameIdxW-1:0]  fi_ff;
   logic                  hit_ff, ld_ff, wbv_ff, last_ff;
   logic [FileW-1:0]      wbf_ff;
   logic [PageW-1:0]      wbp_ff;

   logic file_eq;

   assign hand_in = (hand_ff == LastIdx) ? '0 : hand_ff + 1'b1;
   assign file_eq = valid_ff[scan_ff] && (file_ff[scan_ff] == file_id_ff);

   always_comb begin
      stat               = '0;
      stat.kind          = kind_ff;
      stat.file_match    = file_eq;
      stat.scan_match    = file_eq && (page_ff[scan_ff] == page_no_ff);
      stat.scan_pinned   = pins_ff[scan_ff] != '0;
      stat.scan_pin_zero = pins_ff[scan_ff] == '0;
      stat.scan_dirty    = dirty_ff[scan_ff];
      stat.scan_last     = scan_ff == LastIdx;
      stat.hand_take     = !valid_ff[hand_in] ||
                           (!ref_ff[hand_in] && pins_ff[hand_in] == '0);
      stat.sweep_done    = sweep_cnt_ff == SweepMax;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         dirty_ff     <= '0;
         ref_ff       <= '0;
         for (int i = 0; i < NUM_FRAMES; i++) pins_ff[i] <= '0;
         hand_ff      <= LastIdx;
         scan_ff      <= '0;
         sweep_cnt_ff <= '0;
      end else begin
         if (cmd.scan_clr) begin
            scan_ff      <= '0;
            sweep_cnt_ff <= '0;
         end else if (cmd.scan_step) begin
            scan_ff <= (scan_ff == LastIdx) ? '0 : scan_ff + 1'b1;
         end
         if (cmd.hit_upd) begin
            ref_ff[scan_ff] <= 1'b1;
            if (pins_ff[scan_ff] != PinMax) pins_ff[scan_ff] <= pins_ff[scan_ff] + 1'b1;
         end
         if (cmd.unpin_upd) begin
            pins_ff[scan_ff] <= pins_ff[scan_ff] - 1'b1;
            if (dflag_ff) dirty_ff[scan_ff] <= 1'b1;
         end
         if (cmd.clear_match || cmd.flush_clear) begin
            valid_ff[scan_ff] <= 1'b0;
            dirty_ff[scan_ff] <= 1'b0;
            ref_ff[scan_ff]   <= 1'b0;
            pins_ff[scan_ff]  <= '0;
         end
         if (cmd.hand_step) begin
            hand_ff      <= hand_in;
            sweep_cnt_ff <= sweep_cnt_ff + 1'b1;
            victim_ff    <= hand_in;
            if (valid_ff[hand_in] && ref_ff[hand_in]) ref_ff[hand_in] <= 1'b0;
         end
         if (cmd.place) begin
            valid_ff[victim_ff] <= 1'b1;
            dirty_ff[victim_ff] <= 1'b0;
            ref_ff[victim_ff]   <= 1'b1;
            pins_ff[victim_ff]  <= PinW'(1);
         end
      end
   end

   // Tags and result payload carry no reset.
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         kind_ff    <= req_kind;
         file_id_ff <= req_file_id;
         page_no_ff <= req_page_no;
         dflag_ff   <= req_dirty_flag;
      end
      if (cmd.place) begin
         file_ff[victim_ff] <= file_id_ff;
         page_ff[victim_ff] <= page_no_ff;
      end
      if (cmd.rsp_load) begin
         st_ff   <= cmd.rsp_status;
         hit_ff  <= cmd.rsp_hit;
         ld_ff   <= cmd.rsp_load_needed;
         last_ff <= cmd.rsp_last;
         fi_ff   <= cmd.rsp_frame ?
                    FrameIdxW'(cmd.rsp_wb_scan || cmd.rsp_hit ? scan_ff : victim_ff) : '0;
         if (cmd.rsp_wb_scan) begin
            wbv_ff <= 1'b1;
            wbf_ff <= file_ff[scan_ff];
            wbp_ff <= page_ff[scan_ff];
         end else if (cmd.rsp_wb && valid_ff[victim_ff] && dirty_ff[victim_ff]) begin
            wbv_ff <= 1'b1;
            wbf_ff <= file_ff[victim_ff];
            wbp_ff <= page_ff[victim_ff];
         end else begin
            wbv_ff <= 1'b0;
            wbf_ff <= '0;
            wbp_ff <= '0;
         end
      end
   end

   assign rsp_status          = st_ff;
   assign rsp_frame_index     = fi_ff;
   assign rsp_hit             = hit_ff;
   assign rsp_load_needed     = ld_ff;
   assign rsp_writeback_valid = wbv_ff;
   assign rsp_writeback_file  = wbf_ff;
   assign rsp_writeback_page  = wbp_ff;
   assign rsp_last            = last_ff;

   `CBPM_ASSERT_NEXT(a_place_valid, clock, reset, cmd.place, valid_ff[victim_ff] && ref_ff[victim_ff], "placed frame not valid")
   `CBPM_ASSERT_IMP(a_sweep_bound, clock, reset, cmd.hand_step, sweep_cnt_ff < SweepMax, "sweep ran past two passes")
   `CBPM_ASSERT_IMP(a_unpin_pinned, clock, reset, cmd.unpin_upd, pins_ff[scan_ff] != '0, "unpin of a frame with no pins")

endmodule

/* sv/cbpm_ctrl.sv */
`include "clock_buffer_pool_manager_top_defines.svh"

module cbpm_ctrl
   import cbpm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  cbpm_stat_type stat,
   output cbpm_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE, S_DECODE, S_LOOKUP, S_SWEEP, S_FLUSH, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_last_ff, out_last_in;  // whether the waiting result ends the item
   logic      rsp_take;

   assign rsp_take  = rsp_valid_ff && rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_take ? 1'b0 : rsp_valid_ff;
      out_last_in  = out_last_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.scan_clr = 1'b1;
            case (stat.kind)
               KIND_READ, KIND_UNPIN, KIND_DISPOSE: state_in = S_LOOKUP;
               KIND_ALLOC:                          state_in = S_SWEEP;
               KIND_FLUSH:                          state_in = S_FLUSH;
               default:                             state_in = S_IDLE;
            endcase
         end
         S_LOOKUP: begin
            cmd.rsp_last = 1'b1;
            if (stat.scan_match) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_OUT;
               out_last_in  = 1'b1;
               rsp_valid_in = 1'b1;
               case (stat.kind)
                  KIND_READ: begin
                     cmd.hit_upd   = 1'b1;
                     cmd.rsp_hit   = 1'b1;
                     cmd.rsp_frame = 1'b1;
                  end
                  KIND_UNPIN: begin
                     if (stat.scan_pin_zero) cmd.rsp_status = ST_NOT_PINNED;
                     else cmd.unpin_upd = 1'b1;
                  end
                  default: cmd.clear_match = 1'b1;
               endcase
            end else if (stat.scan_last) begin
               if (stat.kind == KIND_READ) begin
                  state_in = S_SWEEP;
               end else begin
                  cmd.rsp_load = 1'b1;
                  if (stat.kind == KIND_UNPIN) cmd.rsp_status = ST_NOT_FOUND;
                  state_in     = S_OUT;
                  out_last_in  = 1'b1;
                  rsp_valid_in = 1'b1;
               end
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_SWEEP: begin
            // The victim register is written by the step that finds it, so the
            // frame is loaded in the output state on the following cycle.
            cmd.rsp_last = 1'b1;
            if (stat.sweep_done) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = ST_ALL_PINNED;
               state_in       = S_OUT;
               out_last_in    = 1'b1;
               rsp_valid_in   = 1'b1;
            end else begin
               cmd.hand_step = 1'b1;
               if (stat.hand_take) state_in = S_OUT;
            end
            if (stat.hand_take && !stat.sweep_done) begin
               out_last_in  = 1'b1;
               rsp_valid_in = 1'b0;
            end
         end
         S_FLUSH: begin
            if (stat.file_match && stat.scan_pinned) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = ST_PAGE_PINNED;
               cmd.rsp_last   = 1'b1;
               state_in       = S_OUT;
               out_last_in    = 1'b1;
               rsp_valid_in   = 1'b1;
            end else if (stat.file_match && stat.scan_dirty) begin
               cmd.rsp_load    = 1'b1;
               cmd.rsp_frame   = 1'b1;
               cmd.rsp_wb_scan = 1'b1;
               cmd.flush_clear = 1'b1;
               state_in        = S_OUT;
               out_last_in     = 1'b0;
               rsp_valid_in    = 1'b1;
            end else begin
               if (stat.file_match) cmd.flush_clear = 1'b1;
               if (stat.scan_last) begin
                  cmd.rsp_load = 1'b1;
                  cmd.rsp_last = 1'b1;
                  state_in     = S_OUT;
                  out_last_in  = 1'b1;
                  rsp_valid_in = 1'b1;
               end else begin
                  cmd.scan_step = 1'b1;
               end
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff) begin
               // Entered from the sweep with a victim chosen: place it now.
               cmd.rsp_load        = 1'b1;
               cmd.rsp_last        = 1'b1;
               cmd.rsp_frame       = 1'b1;
               cmd.rsp_wb          = 1'b1;
               cmd.rsp_load_needed = (stat.kind == KIND_READ);
               cmd.place           = 1'b1;
               rsp_valid_in        = 1'b1;
            end else if (rsp_take) begin
               if (out_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  // A dirty flush frame was reported and is now clear. At the
                  // final frame the scan stays put so that the walk ends there.
                  if (!stat.scan_last) cmd.scan_step = 1'b1;
                  state_in = S_FLUSH;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         out_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         out_last_ff  <= out_last_in;
      end
   end

   `CBPM_ASSERT_IMP(a_rsp_in_out, clock, reset, rsp_valid_ff, state_ff == S_OUT, "result shown outside output state")
   `CBPM_ASSERT_IMP(a_no_accept_busy, clock, reset, req_ready, !rsp_valid_ff, "ready while a result waits")
   `CBPM_ASSERT_NEXT(a_accept_decode, clock, reset, req_valid && req_ready, state_ff == S_DECODE, "accepted item not decoded")

endmodule
